// ===== hdl/amt_pkg.sv =====
// Shared types, codes and constants of the aging membership table.
`timescale 1ns / 1ps

package amt_pkg;

   // Table geometry and fixed field widths
   localparam int AMT_MAX_MEMBERS = 64;
   localparam int AMT_ADDR_W      = 32;
   localparam int AMT_TIME_W      = 32;
   localparam int AMT_ENTRY_W     = AMT_ADDR_W + AMT_TIME_W;
   localparam int AMT_REG_W       = 16;

   // Configuration reset values
   localparam logic [AMT_ADDR_W-1:0] OWN_ADDRESS_RESET  = 32'd0;
   localparam logic [AMT_REG_W-1:0]  MAX_INTERVAL_RESET = 16'd270;
   localparam logic [AMT_REG_W-1:0]  JITTER_RESET       = 16'd30;

   // Request codes
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_EXPIRE = 2'd2,
      REQ_QUERY  = 2'd3
   } req_code_type;

   // Response status codes
   typedef enum logic [3:0] {
      ST_ADDED     = 4'd0,
      ST_REFRESHED = 4'd1,
      ST_SELF      = 4'd2,
      ST_FULL      = 4'd3,
      ST_REMOVED   = 4'd4,
      ST_NOT_FOUND = 4'd5,
      ST_EXPIRED   = 4'd6,
      ST_NONE_DUE  = 4'd7,
      ST_NEXT      = 4'd8,
      ST_EMPTY     = 4'd9
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_OWN_ADDRESS  = 2'd0,
      CSR_MAX_INTERVAL = 2'd1,
      CSR_JITTER       = 2'd2
   } csr_index_type;

   // Configuration values handed to the controller
   typedef struct packed {
      logic [AMT_ADDR_W-1:0] own_address;
      logic [AMT_REG_W-1:0]  max_interval;
      logic [AMT_REG_W-1:0]  jitter;
   } cfg_type;

endpackage

// ===== hdl/amt_if.sv =====
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface amt_req_if;
   import amt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            req_type;
   logic [AMT_ADDR_W-1:0] member_address;
   logic [AMT_TIME_W-1:0] lifetime;
   logic [AMT_TIME_W-1:0] now_seconds;

   modport source (output valid, req_type, member_address, lifetime, now_seconds,
                   input ready);
   modport sink   (input valid, req_type, member_address, lifetime, now_seconds,
                   output ready);
endinterface

interface amt_rsp_if #(parameter int CNT_W = $clog2(amt_pkg::AMT_MAX_MEMBERS + 1));
   import amt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [3:0]            status;
   logic [AMT_ADDR_W-1:0] found_address;
   logic [AMT_TIME_W-1:0] time_left;
   logic [CNT_W-1:0]      member_count;

   modport source (output valid, status, found_address, time_left, member_count,
                   input ready);
   modport sink   (input valid, status, found_address, time_left, member_count,
                   output ready);
endinterface

interface amt_csr_if;
   import amt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            reg_index;
   logic [AMT_ADDR_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/amt_ram.sv =====
// Simple dual-port table memory with registered read data.
`timescale 1ns / 1ps

module amt_ram #(
   parameter int DEPTH = amt_pkg::AMT_MAX_MEMBERS,
   parameter int WIDTH = amt_pkg::AMT_ENTRY_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/amt_ctrl.sv =====
// Request sequencer: scans the table memory, updates it and forms the response.
`timescale 1ns / 1ps

module amt_ctrl #(
   parameter int MAX_MEMBERS = amt_pkg::AMT_MAX_MEMBERS,
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1),
   localparam int IDX_W = $clog2(MAX_MEMBERS)
) (
   input  logic                           clock,
   input  logic                           reset,
   amt_req_if.sink                        req_bus,
   amt_rsp_if.source                      rsp_bus,
   input  amt_pkg::cfg_type               cfg,
   output logic                           ram_wr_en,
   output logic [IDX_W-1:0]               ram_wr_addr,
   output logic [amt_pkg::AMT_ENTRY_W-1:0] ram_wr_data,
   output logic [IDX_W-1:0]               ram_rd_addr,
   input  logic [amt_pkg::AMT_ENTRY_W-1:0] ram_rd_data
);
   import amt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_CALC = 6'b000010,
      S_SCAN = 6'b000100,
      S_LAST = 6'b001000,
      S_MOVE = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   req_code_type          op_ff, op_in;
   logic [AMT_ADDR_W-1:0] addr_ff, addr_in;
   logic [AMT_TIME_W-1:0] life_ff, life_in;
   logic [AMT_TIME_W-1:0] now_ff, now_in;
   logic [AMT_TIME_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [AMT_TIME_W-1:0] best_ff, best_in;
   logic                  got_ff, got_in;
   status_type            st_ff, st_in;
   logic [AMT_ADDR_W-1:0] found_ff, found_in;
   logic [AMT_TIME_W-1:0] left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [AMT_ADDR_W-1:0] rsp_found_ff, rsp_found_in;
   logic [AMT_TIME_W-1:0] rsp_left_ff, rsp_left_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [AMT_ADDR_W-1:0] q_addr;
   logic [AMT_TIME_W-1:0] q_exp;
   logic [AMT_TIME_W-1:0] life_sel;
   logic [AMT_TIME_W-1:0] expiry;
   logic [IDX_W-1:0]      last_idx;
   logic                  issue;
   logic                  hit;
   logic                  scan_end;
   logic                  out_free;

   // Split the stored entry and derive the scan controls
   assign q_addr   = ram_rd_data[AMT_ENTRY_W-1:AMT_TIME_W];
   assign q_exp    = ram_rd_data[AMT_TIME_W-1:0];
   assign life_sel = (life_ff > {15'd0, cfg.max_interval, 1'b0}) ?
                     {16'd0, cfg.max_interval} : life_ff;
   assign expiry   = base_ff + now_ff;
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign issue    = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign scan_end = !rd_vld_ff && (rd_idx_ff >= count_ff);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      hit = 1'b0;
      if (rd_vld_ff) begin
         case (op_ff)
            REQ_ADD, REQ_REMOVE: hit = (q_addr == addr_ff);
            REQ_EXPIRE:          hit = (q_exp <= now_ff);
            default:             hit = 1'b0;
         endcase
      end
   end

   assign ram_rd_addr = (state_ff == S_LAST) ? last_idx : rd_idx_ff[IDX_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      life_in       = life_ff;
      now_in        = now_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      best_in       = best_ff;
      got_in        = got_ff;
      st_in         = st_ff;
      found_in      = found_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cmp_idx_ff;
      ram_wr_data   = {addr_ff, expiry};

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in     = req_code_type'(req_bus.req_type);
               addr_in   = req_bus.member_address;
               life_in   = req_bus.lifetime;
               now_in    = req_bus.now_seconds;
               best_in   = '1;
               got_in    = 1'b0;
               found_in  = '0;
               left_in   = '0;
               rd_idx_in = '0;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            base_in = life_sel + {16'd0, cfg.jitter};
            if ((op_ff == REQ_ADD) && (addr_ff == cfg.own_address)) begin
               st_in    = ST_SELF;
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue one read per cycle, compare the entry read last cycle
            if (issue) begin
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               rd_vld_in  = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            end
            if (rd_vld_ff && (op_ff == REQ_QUERY) && (q_exp < best_ff)) begin
               best_in = q_exp;
               got_in  = 1'b1;
            end
            if (hit) begin
               rd_vld_in  = 1'b0;
               hit_idx_in = cmp_idx_ff;
               if (op_ff == REQ_ADD) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cmp_idx_ff;
                  st_in       = ST_REFRESHED;
                  state_in    = S_DONE;
               end else begin
                  found_in = (op_ff == REQ_EXPIRE) ? q_addr : '0;
                  state_in = S_LAST;
               end
            end else if (scan_end) begin
               state_in = S_DONE;
               case (op_ff)
                  REQ_ADD: begin
                     if (count_ff >= CNT_W'(MAX_MEMBERS)) begin
                        st_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                        st_in       = ST_ADDED;
                     end
                  end
                  REQ_REMOVE: st_in = ST_NOT_FOUND;
                  REQ_EXPIRE: st_in = ST_NONE_DUE;
                  default: begin
                     left_in = got_ff ? (best_ff - now_ff) : '1;
                     st_in   = (count_ff == '0) ? ST_EMPTY : ST_NEXT;
                  end
               endcase
            end
         end
         S_LAST: begin
            // Read address is the last entry this cycle
            state_in = S_MOVE;
         end
         S_MOVE: begin
            // Move the last entry into the freed slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_idx_ff;
            ram_wr_data = ram_rd_data;
            count_in    = count_ff - CNT_W'(1);
            st_in       = (op_ff == REQ_REMOVE) ? ST_REMOVED : ST_EXPIRED;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // Hold until the response register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_found_in  = found_ff;
               rsp_left_in   = left_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      life_ff       <= life_in;
      now_ff        <= now_in;
      base_ff       <= base_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      best_ff       <= best_in;
      got_ff        <= got_in;
      st_ff         <= st_in;
      found_ff      <= found_in;
      left_ff       <= left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_address  = rsp_found_ff;
   assign rsp_bus.time_left      = rsp_left_ff;
   assign rsp_bus.member_count   = rsp_count_ff;

endmodule

// ===== hdl/aging_membership_table.sv =====
// Aging membership table: a table of member addresses with absolute expiry
// seconds, held in one table memory. Each request carries the current time.
// Requests are taken one at a time. An add, removal or expiry scans the valid
// entries one per cycle through the memory read port and stops at the first
// match; a query scans every valid entry. An add from the own address answers
// without a scan. A removal or expiry that finds its entry then moves the last
// entry into the freed slot. The next request is taken in the cycle after the
// response is loaded. A finished response waits in an output register while
// the next request is taken; a second finished response holds until the first
// one is taken. After reset the table is empty and ready at once.
`timescale 1ns / 1ps

module aging_membership_table #(
   parameter int MAX_MEMBERS = amt_pkg::AMT_MAX_MEMBERS
) (
   input  logic      clock,
   input  logic      reset,
   amt_req_if.sink   req_bus,
   amt_rsp_if.source rsp_bus,
   amt_csr_if.sink   csr_bus
);
   import amt_pkg::*;

   localparam int IDX_W = $clog2(MAX_MEMBERS);

   cfg_type                cfg_ff;
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [AMT_ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [AMT_ENTRY_W-1:0] ram_rd_data;

   // Configuration registers; writes to unknown indexes are dropped
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address  <= OWN_ADDRESS_RESET;
         cfg_ff.max_interval <= MAX_INTERVAL_RESET;
         cfg_ff.jitter       <= JITTER_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_OWN_ADDRESS:  cfg_ff.own_address  <= csr_bus.wr_data;
            CSR_MAX_INTERVAL: cfg_ff.max_interval <= csr_bus.wr_data[AMT_REG_W-1:0];
            CSR_JITTER:       cfg_ff.jitter       <= csr_bus.wr_data[AMT_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   amt_ram #(
      .DEPTH (MAX_MEMBERS),
      .WIDTH (AMT_ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   amt_ctrl #(
      .MAX_MEMBERS (MAX_MEMBERS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .cfg         (cfg_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule

// ===== hdl/amt_checker.sv =====
// Port-level checks of the response channel, bound to the top level.
`timescale 1ns / 1ps

module amt_checker #(
   parameter int MAX_MEMBERS = amt_pkg::AMT_MAX_MEMBERS,
   localparam int CNT_W = $clog2(MAX_MEMBERS + 1)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [3:0]                    rsp_status,
   input logic [amt_pkg::AMT_ADDR_W-1:0] rsp_found_address,
   input logic [amt_pkg::AMT_TIME_W-1:0] rsp_time_left,
   input logic [CNT_W-1:0]              rsp_member_count
);
   import amt_pkg::*;

   // Count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_member_count <= CNT_W'(MAX_MEMBERS)))
      else $error("member count above table size");

   // Only an expiry reports an address
   a_found_only_expired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_EXPIRED)) |-> (rsp_found_address == '0))
      else $error("found address on a non-expiry response");

   // Only a query reports time left
   a_left_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_NEXT) && (rsp_status != ST_EMPTY))
      |-> (rsp_time_left == '0))
      else $error("time left on a non-query response");

   // An empty table reports no members and all ones
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY))
      |-> ((rsp_member_count == '0) && (rsp_time_left == '1)))
      else $error("empty response with members or time left");

   // A waiting response holds its payload until it is taken
   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_address) && $stable(rsp_time_left) &&
      $stable(rsp_member_count)))
      else $error("response dropped or changed while waiting");

endmodule

bind aging_membership_table amt_checker #(
   .MAX_MEMBERS (MAX_MEMBERS)
) u_amt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_found_address (rsp_bus.found_address),
   .rsp_time_left     (rsp_bus.time_left),
   .rsp_member_count  (rsp_bus.member_count)
);
